/* rtl/wlr_pkg.sv */
// Package for the word letter reverser.
// Holds the word store sizes, the letter test and the control and status
// types passed between the sequencer and the word store.
package wlr_pkg;

   localparam int MAX_WORD = 32;
   localparam int CountW   = $clog2(MAX_WORD + 1);
   localparam int AddrW    = $clog2(MAX_WORD);
   localparam int CharW    = 8;

   localparam logic [CharW-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CharW-1:0] UPPER_A      = 8'h41;
   localparam logic [CharW-1:0] UPPER_Z      = 8'h5A;
   localparam logic [CharW-1:0] LOWER_A      = 8'h61;
   localparam logic [CharW-1:0] LOWER_Z      = 8'h7A;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [CharW-1:0] wdata;
   } store_ctrl_type;

   typedef struct packed {
      logic [CountW-1:0] count;
      logic              empty;
      logic              full;
      logic [CharW-1:0]  rd_data;
   } store_stat_type;

   function automatic logic is_letter(input logic [CharW-1:0] ch);
      return ((ch >= UPPER_A) && (ch <= UPPER_Z)) || ((ch >= LOWER_A) && (ch <= LOWER_Z));
   endfunction

endpackage

/* rtl/wlr_if.sv */
// Handshake channels of the word letter reverser.
// One interface for the request words and one for the response words;
// both depend on wlr_pkg for the character width.
interface wlr_req_if;
   import wlr_pkg::*;

   logic             valid;
   logic             ready;
   logic [CharW-1:0] in_char;
   logic             end_of_string;

   modport source (output valid, output in_char, output end_of_string, input ready);
   modport sink   (input valid, input in_char, input end_of_string, output ready);
endinterface

interface wlr_rsp_if;
   import wlr_pkg::*;

   logic             valid;
   logic             ready;
   logic [CharW-1:0] out_char;
   logic             out_last;
   logic             word_split;

   modport source (output valid, output out_char, output out_last, output word_split,
                   input ready);
   modport sink   (input valid, input out_char, input out_last, input word_split,
                   output ready);
endinterface

/* rtl/wlr_store.sv */
// Last-in-first-out word store of the word letter reverser.
// A memory with one write port and one registered read port plus the fill
// count; depends on wlr_pkg.
module wlr_store (
   input  logic                    clock,
   input  logic                    reset,
   input  wlr_pkg::store_ctrl_type ctrl,
   output wlr_pkg::store_stat_type stat
);
   import wlr_pkg::*;

   logic [CharW-1:0]  mem [MAX_WORD];
   logic [CharW-1:0]  rd_data_ff;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [CountW-1:0] count_dec;

   assign count_dec = count_ff - CountW'(1);

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CountW'(1);
      end else if (ctrl.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[count_ff[AddrW-1:0]] <= ctrl.wdata;
      end
      if (ctrl.pop) begin
         rd_data_ff <= mem[count_dec[AddrW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count   = count_ff;
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CountW'(MAX_WORD));
   assign stat.rd_data = rd_data_ff;

endmodule

/* rtl/wlr_seq.sv */
// Sequencer of the word letter reverser.
// Takes request words, drives the word store and holds the response
// register; depends on wlr_pkg and the channel interfaces.
module wlr_seq (
   input  logic                    clock,
   input  logic                    reset,
   wlr_req_if.sink                 req,
   wlr_rsp_if.source               rsp,
   output wlr_pkg::store_ctrl_type ctrl,
   input  wlr_pkg::store_stat_type stat
);
   import wlr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_FLUSH   = 4'b0010,
      ST_CHAR    = 4'b0100,
      ST_NEWLINE = 4'b1000
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [CharW-1:0] char_ff, char_in;
   logic             eos_ff, eos_in;
   logic             letter_ff, letter_in;
   logic             split_ff, split_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CharW-1:0] rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_split_ff, rsp_split_in;
   logic             out_free;
   logic             out_load;
   logic             accept;
   logic             in_letter;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && (state_ff == ST_IDLE);
   assign in_letter = is_letter(req.in_char);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      eos_in       = eos_ff;
      letter_in    = letter_ff;
      split_in     = split_ff;
      rd_pend_in   = rd_pend_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_split_in = rsp_split_ff;
      out_load     = 1'b0;
      ctrl.push    = 1'b0;
      ctrl.pop     = 1'b0;
      ctrl.wdata   = req.in_char;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in   = req.in_char;
               eos_in    = req.end_of_string;
               letter_in = in_letter;
               split_in  = 1'b0;
               if (in_letter && !stat.full) begin
                  ctrl.push = 1'b1;
                  if (req.end_of_string) begin
                     state_in = ST_FLUSH;
                  end
               end else if (in_letter) begin
                  split_in = 1'b1;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (rd_pend_ff && out_free) begin
               out_load     = 1'b1;
               rsp_char_in  = stat.rd_data;
               rsp_last_in  = 1'b0;
               rsp_split_in = split_ff;
               rd_pend_in   = 1'b0;
            end
            if (!stat.empty && (!rd_pend_ff || out_free)) begin
               ctrl.pop   = 1'b1;
               rd_pend_in = 1'b1;
            end else if (stat.empty && !rd_pend_ff) begin
               if (letter_ff && split_ff) begin
                  // The letter that found the store full starts the next word.
                  ctrl.push  = 1'b1;
                  ctrl.wdata = char_ff;
                  split_in   = 1'b0;
                  state_in   = eos_ff ? ST_FLUSH : ST_IDLE;
               end else if (letter_ff) begin
                  state_in = ST_NEWLINE;
               end else begin
                  state_in = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_char_in  = char_ff;
               rsp_last_in  = 1'b0;
               rsp_split_in = 1'b0;
               state_in     = eos_ff ? ST_NEWLINE : ST_IDLE;
            end
         end
         ST_NEWLINE: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_char_in  = NEWLINE_CHAR;
               rsp_last_in  = 1'b1;
               rsp_split_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      eos_ff       <= eos_in;
      letter_ff    <= letter_in;
      split_ff     <= split_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_split_ff <= rsp_split_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_char   = rsp_char_ff;
   assign rsp.out_last   = rsp_last_ff;
   assign rsp.word_split = rsp_split_ff;

endmodule

/* rtl/word_letter_reverser.sv */
// Word letter reverser: reverses each run of ASCII letters in a string.
// A letter that fits in the word store is pushed when taken. For other bytes the held
// letters are popped out in reverse order, then the byte passes through, and a closing
// newline ends each string; response stalls hold the flow, and no new byte is taken meanwhile.
// Response words leave from a response register.
// Reset clears the sequencer, the response register and the fill count, not the store.
module word_letter_reverser (
   input  logic      clock,
   input  logic      reset,
   wlr_req_if.sink   req_chan,
   wlr_rsp_if.source rsp_chan
);
   import wlr_pkg::*;

   store_ctrl_type store_ctrl;
   store_stat_type store_stat;

   wlr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .ctrl  (store_ctrl),
      .stat  (store_stat)
   );

   wlr_store u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (store_ctrl),
      .stat  (store_stat)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.pop |-> !store_stat.empty)
      else $error("Word store popped while empty.");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.push |-> !store_stat.full && !store_ctrl.pop)
      else $error("Word store pushed while full or while popping.");

   a_letter_held: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && is_letter(req_chan.in_char)
       && !store_stat.full)
      |=> store_stat.count == $past(store_stat.count) + CountW'(1))
      else $error("Accepted letter was not held in the word store.");

endmodule

/* tb/wlr_reversal_checker.sv */
// Checker for the word letter reverser: watches both handshake channels,
// predicts the response words from the request words and compares them.
// Depends on wlr_pkg and on the channel interfaces in wlr_if.sv.
`timescale 1ns / 1ps

module wlr_reversal_checker
   import wlr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wlr_req_if   req_mon,
   wlr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [CharW-1:0] ch;
      logic             last;
      logic             split;
   } rev_word_type;

   rev_word_type     expected_words[$];
   logic [CharW-1:0] letter_stack[MAX_WORD];
   int               held_letters;
   int               errors;

   initial begin
      errors       = 0;
      held_letters = 0;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic flush_held_word(input logic split);
      while (held_letters > 0) begin
         held_letters--;
         expected_words.push_back('{ch: letter_stack[held_letters], last: 1'b0, split: split});
      end
   endtask

   task automatic predict_reversal(input logic [CharW-1:0] ch, input logic eos);
      if (ch inside {[UPPER_A:UPPER_Z], [LOWER_A:LOWER_Z]}) begin
         if (held_letters >= MAX_WORD) begin
            flush_held_word(1'b1);
         end
         letter_stack[held_letters] = ch;
         held_letters++;
      end else begin
         flush_held_word(1'b0);
         expected_words.push_back('{ch: ch, last: 1'b0, split: 1'b0});
      end
      if (eos) begin
         flush_held_word(1'b0);
         expected_words.push_back('{ch: NEWLINE_CHAR, last: 1'b1, split: 1'b0});
      end
   endtask

   always @(posedge clock) begin
      rev_word_type want;
      if (reset) begin
         held_letters = 0;
         expected_words.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_reversal(req_mon.in_char, req_mon.end_of_string);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_mon.out_char));
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.out_char !== want.ch) begin
                  report_mismatch($sformatf("out_char %h, predicted %h",
                                            rsp_mon.out_char, want.ch));
               end
               if (rsp_mon.out_last !== want.last) begin
                  report_mismatch($sformatf("out_last %b, predicted %b on char %h",
                                            rsp_mon.out_last, want.last, want.ch));
               end
               if (rsp_mon.word_split !== want.split) begin
                  report_mismatch($sformatf("word_split %b, predicted %b on char %h",
                                            rsp_mon.word_split, want.split, want.ch));
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_words.size();
   end

endmodule

/* tb/word_letter_reverser_tb.sv */
// Testbench top for the word letter reverser: drives strings of bytes with
// random gaps and response stalls and gives the verdict from the checker.
// Depends on wlr_pkg, wlr_if.sv, wlr_reversal_checker and the block itself.
`timescale 1ns / 1ps

module word_letter_reverser_tb;
   import wlr_pkg::*;

   localparam int RANDOM_ITEMS = 95;
   localparam int STEADY_AFTER = 70;
   localparam int IDLE_LIMIT   = 2000;

   logic clock;
   logic reset;
   logic steady;
   int   fail_count;
   int   pending;
   int   sent;

   wlr_req_if req_chan ();
   wlr_rsp_if rsp_chan ();

   word_letter_reverser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wlr_reversal_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [CharW-1:0] random_letter();
      int k;
      k = $urandom_range(0, 51);
      if (k < 26) begin
         return UPPER_A + 8'(k);
      end
      return LOWER_A + 8'(k - 26);
   endfunction

   function automatic logic [CharW-1:0] random_non_letter();
      logic [CharW-1:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (is_letter(b));
      return b;
   endfunction

   task automatic send_byte(input logic [CharW-1:0] ch, input logic eos);
      int gap;
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.in_char       <= ch;
      req_chan.end_of_string <= eos;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      sent++;
   endtask

   task automatic send_string(input logic [CharW-1:0] text[$]);
      for (int i = 0; i < text.size(); i++) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   // Response side: random bursts of ready and stall, always ready once the bench is steady.
   initial begin
      int   burst;
      logic level;
      wait (!reset);
      forever begin
         if (steady) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            burst = $urandom_range(1, 18);
            level = ($urandom_range(0, 2) != 0);
            repeat (burst) begin
               @(negedge clock);
               rsp_chan.ready <= level;
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("word_letter_reverser: mismatch");
      $finish;
   end

   initial begin
      logic [CharW-1:0] text[$];
      int               words;
      int               len;
      int               total;
      logic             first_long;

      reset                  = 1'b1;
      steady                 = 1'b0;
      sent                   = 0;
      req_chan.valid         = 1'b0;
      req_chan.in_char       = '0;
      req_chan.end_of_string = 1'b0;
      rsp_chan.ready         = 1'b0;
      first_long             = 1'b1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Letters before a digit, then the edges of both letter ranges,
      // high bytes, a string ending on a letter and one-byte strings.
      text = '{8'h41, 8'h62, 8'h31};
      send_string(text);
      text = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B,
               8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20, 8'h71};
      send_string(text);
      text = '{NEWLINE_CHAR};
      send_string(text);
      text = '{8'h5A};
      send_string(text);
      text = '{8'h47, 8'h6F, 8'h21};
      send_string(text);

      total = sent + RANDOM_ITEMS;
      while (sent < total) begin
         text.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
         end else begin
            words = $urandom_range(1, 4);
            for (int w = 0; w < words; w++) begin
               if (w > 0 || $urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(1, 3)) text.push_back(random_non_letter());
               end
               if (first_long || $urandom_range(0, 11) == 0) begin
                  len = $urandom_range(MAX_WORD - 1, 2 * MAX_WORD + 1);
               end else begin
                  len = $urandom_range(1, 8);
               end
               first_long = 1'b0;
               repeat (len) text.push_back(random_letter());
            end
            if ($urandom_range(0, 1) == 0) begin
               text.push_back(random_non_letter());
            end
         end
         if (sent >= total - RANDOM_ITEMS + STEADY_AFTER) begin
            steady = 1'b1;
         end
         send_string(text);
      end

      steady = 1'b1;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (64) @(negedge clock);

      if (fail_count == 0) begin
         $display("word_letter_reverser: match");
      end else begin
         $display("word_letter_reverser: mismatch");
      end
      $finish;
   end

endmodule
